### hw/rtl/bollinger_band_tracker_unit_assert.svh
// Assertion macros for the Bollinger band tracker.
`ifndef BOLLINGER_BAND_TRACKER_UNIT_ASSERT_SVH
`define BOLLINGER_BAND_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BBT_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bollinger band tracker check failed");
`define BBT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("bollinger band tracker check failed");
`else
`define BBT_ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`define BBT_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

### hw/rtl/bbt_pkg.sv
`default_nettype none
package bbt_pkg;

  localparam int FIELD_W = 24;
  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

  localparam int MULT_W = 3;
  localparam logic [MULT_W-1:0] MULT_RESET = 3'd2;

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_BAND_MULTIPLIER = '0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_START,
    ST_SQ_WAIT,
    ST_SUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MSQ_START,
    ST_MSQ_WAIT,
    ST_VAR,
    ST_SQRT_START,
    ST_SQRT_WAIT,
    ST_BAND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic ready;
    logic sq_start;
    logic sum_upd;
    logic div_start;
    logic msq_start;
    logic var_ld;
    logic sqrt_start;
    logic band_ld;
    logic out_ld;
  } ctl_t;

endpackage
`default_nettype wire

### hw/rtl/bbt_ring.sv
`default_nettype none
module bbt_ring #(
  parameter int DEPTH = 20,
  parameter int W = 24
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [W-1:0]             wdata,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // read returns the entry being replaced
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bbt_sq.sv
`default_nettype none
module bbt_sq #(
  parameter int W = 24
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [W-1:0]   x,
  output logic                done,
  output logic      [2*W-1:0] prod
);

  localparam int C_W = $clog2(W + 1);

  logic [2*W-1:0] mcand;
  logic [W-1:0]   mplier;
  logic [C_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == C_W'(1));
      if (start) begin
        cnt <= C_W'(W);
      end else if (cnt != '0) begin
        cnt <= cnt - C_W'(1);
      end
    end
  end

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= (2*W)'(x);
      mplier <= x;
      prod   <= '0;
    end else if (cnt != '0) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bbt_divw.sv
`default_nettype none
module bbt_divw #(
  parameter int D_W = 29,
  parameter int DIVISOR = 20
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [D_W-1:0] dividend,
  output logic                done,
  output logic      [D_W-1:0] quotient
);

  localparam int R_W = $clog2(DIVISOR) + 1;
  localparam int C_W = $clog2(D_W + 1);

  logic [R_W-1:0] rem;
  logic [R_W-1:0] trial;
  logic           ge;
  logic [C_W-1:0] cnt;

  assign trial = {rem[R_W-2:0], quotient[D_W-1]};
  assign ge    = (trial >= R_W'(DIVISOR));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == C_W'(1));
      if (start) begin
        cnt <= C_W'(D_W);
      end else if (cnt != '0) begin
        cnt <= cnt - C_W'(1);
      end
    end
  end

  // restoring division; dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (cnt != '0) begin
      rem      <= ge ? trial - R_W'(DIVISOR) : trial;
      quotient <= {quotient[D_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bbt_sqrt.sv
`default_nettype none
module bbt_sqrt #(
  parameter int N = 24
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [2*N-1:0] radicand,
  output logic                done,
  output logic      [N-1:0]   root
);

  localparam int C_W = $clog2(N + 1);

  logic [2*N-1:0] rad;
  logic [N+1:0]   rem;
  logic [N+1:0]   t;
  logic [N+1:0]   trial;
  logic           ge;
  logic [C_W-1:0] cnt;

  assign t     = {rem[N-1:0], rad[2*N-1:2*N-2]};
  assign trial = {root, 2'b01};
  assign ge    = (t >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == C_W'(1));
      if (start) begin
        cnt <= C_W'(N);
      end else if (cnt != '0) begin
        cnt <= cnt - C_W'(1);
      end
    end
  end

  // one root bit per cycle, two radicand bits consumed
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      rad  <= rad << 2;
      rem  <= ge ? t - trial : t;
      root <= {root[N-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bollinger_band_tracker_unit.sv
`default_nettype none
// Channel  Direction  Payload
// s_*      in         tdata[23:0] close_price
// m_*      out        tdata moving_average, price_sigma, upper_band, lower_band;
//                     tuser window_full
// APB      in/out     reg 0 (addr 0): band_multiplier[2:0]
//
// One request at a time. With a full window a request passes through the
// serial squarers, the bit-serial divider over the square sum and the
// serial square root; while the window fills, only the squarers run.
// The output register holds a result until taken; the next request is
// accepted meanwhile. Ring read data is used only after every entry has
// been written, so the ring needs no clearing after reset.
module bollinger_band_tracker_unit #(
  parameter int WINDOW = 20,
  parameter int PRICE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [23:0]                   s_tdata,   // close_price
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // moving_average, price_sigma, upper_band, lower_band
  output logic      [95:0]                   m_tdata,
  output logic                               m_tuser,   // window_full
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bbt_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  localparam int FW     = bbt_pkg::FIELD_W;
  localparam int PW     = (PRICE_BITS < FW) ? PRICE_BITS : FW;
  localparam int LW     = $clog2(WINDOW);
  localparam int SW     = PW + LW;
  localparam int QW     = 2 * PW + LW;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int OW     = PW + 3;
  localparam int UW     = (PW + 4 > FW + 1) ? PW + 4 : FW + 1;
  localparam int MW     = bbt_pkg::MULT_W;

  bbt_pkg::state_t state, state_next;
  bbt_pkg::ctl_t   ctl;

  logic [MW-1:0]     band_mult;
  logic [LW-1:0]     ptr;
  logic [FILL_W-1:0] fill_count;
  logic              evict;
  logic              full_now;
  logic [PW-1:0]     price;
  logic [SW-1:0]     running_sum;
  logic [QW-1:0]     running_sq;
  logic [PW-1:0]     old_price;
  logic [PW-1:0]     old_gated;
  logic [PW-1:0]     sq_in;
  logic [2*PW-1:0]   sq_new;
  logic [2*PW-1:0]   sq_old;
  logic              sq_done;
  logic [SW-1:0]     sum_q;
  logic [QW-1:0]     sq_q;
  logic              div_done;
  logic [PW-1:0]     mean;
  logic [2*PW-1:0]   msq;
  logic [2*PW-1:0]   variance;
  logic [PW-1:0]     sigma;
  logic              sqrt_done;
  logic [OW-1:0]     off;
  logic [UW-1:0]     upper;
  logic [PW-1:0]     lower;
  logic [FW-1:0]     res_avg;
  logic [FW-1:0]     res_std;
  logic [FW-1:0]     res_upper;
  logic [FW-1:0]     res_lower;
  logic              res_full;
  logic              accept;
  logic              cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[bbt_pkg::ADDR_W-1:2] == bbt_pkg::REG_BAND_MULTIPLIER);
  assign prdata = (paddr[bbt_pkg::ADDR_W-1:2] == bbt_pkg::REG_BAND_MULTIPLIER) ?
                  32'(band_mult) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_mult <= bbt_pkg::MULT_RESET;
    end else if (cfg_wr) begin
      band_mult <= pwdata[MW-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bbt_pkg::ST_IDLE:       if (s_tvalid) state_next = bbt_pkg::ST_SQ_START;
      bbt_pkg::ST_SQ_START:   state_next = bbt_pkg::ST_SQ_WAIT;
      bbt_pkg::ST_SQ_WAIT:    if (sq_done) state_next = bbt_pkg::ST_SUM;
      bbt_pkg::ST_SUM:        state_next = full_now ? bbt_pkg::ST_DIV_START : bbt_pkg::ST_OUT;
      bbt_pkg::ST_DIV_START:  state_next = bbt_pkg::ST_DIV_WAIT;
      bbt_pkg::ST_DIV_WAIT:   if (div_done) state_next = bbt_pkg::ST_MSQ_START;
      bbt_pkg::ST_MSQ_START:  state_next = bbt_pkg::ST_MSQ_WAIT;
      bbt_pkg::ST_MSQ_WAIT:   if (sq_done) state_next = bbt_pkg::ST_VAR;
      bbt_pkg::ST_VAR:        state_next = bbt_pkg::ST_SQRT_START;
      bbt_pkg::ST_SQRT_START: state_next = bbt_pkg::ST_SQRT_WAIT;
      bbt_pkg::ST_SQRT_WAIT:  if (sqrt_done) state_next = bbt_pkg::ST_BAND;
      bbt_pkg::ST_BAND:       state_next = bbt_pkg::ST_OUT;
      bbt_pkg::ST_OUT:        if (!m_tvalid || m_tready) state_next = bbt_pkg::ST_IDLE;
      default:                state_next = bbt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      bbt_pkg::ST_IDLE:       ctl.ready      = 1'b1;
      bbt_pkg::ST_SQ_START:   ctl.sq_start   = 1'b1;
      bbt_pkg::ST_SUM:        ctl.sum_upd    = 1'b1;
      bbt_pkg::ST_DIV_START:  ctl.div_start  = 1'b1;
      bbt_pkg::ST_MSQ_START:  ctl.msq_start  = 1'b1;
      bbt_pkg::ST_VAR:        ctl.var_ld     = 1'b1;
      bbt_pkg::ST_SQRT_START: ctl.sqrt_start = 1'b1;
      bbt_pkg::ST_BAND:       ctl.band_ld    = 1'b1;
      bbt_pkg::ST_OUT:        ctl.out_ld     = !m_tvalid || m_tready;
      default:                ;
    endcase
  end

  assign s_tready = ctl.ready;
  assign accept   = s_tvalid && s_tready;

  // window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      fill_count <= '0;
    end else if (accept) begin
      ptr <= (ptr == LW'(WINDOW - 1)) ? '0 : ptr + LW'(1);
      if (fill_count < FILL_W'(WINDOW)) begin
        fill_count <= fill_count + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      price    <= s_tdata[PW-1:0];
      evict    <= (fill_count == FILL_W'(WINDOW));
      full_now <= (fill_count >= FILL_W'(WINDOW - 1));
    end
  end

  bbt_ring #(.DEPTH(WINDOW), .W(PW)) u_ring (
    .clk   (clk),
    .en    (accept),
    .addr  (ptr),
    .wdata (s_tdata[PW-1:0]),
    .rdata (old_price)
  );

  assign old_gated = evict ? old_price : '0;
  assign sq_in     = ctl.msq_start ? mean : price;

  bbt_sq #(.W(PW)) u_sq_new (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.sq_start || ctl.msq_start),
    .x     (sq_in),
    .done  (sq_done),
    .prod  (sq_new)
  );

  bbt_sq #(.W(PW)) u_sq_old (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.sq_start),
    .x     (old_gated),
    .done  (),
    .prod  (sq_old)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      running_sq  <= '0;
    end else if (ctl.sum_upd) begin
      running_sum <= running_sum - SW'(old_gated) + SW'(price);
      running_sq  <= running_sq - QW'(sq_old) + QW'(sq_new);
    end
  end

  bbt_divw #(.D_W(SW), .DIVISOR(WINDOW)) u_div_sum (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (running_sum),
    .done     (),
    .quotient (sum_q)
  );

  // the wider dividend finishes last
  bbt_divw #(.D_W(QW), .DIVISOR(WINDOW)) u_div_sq (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (running_sq),
    .done     (div_done),
    .quotient (sq_q)
  );

  assign mean = sum_q[PW-1:0];
  assign msq  = sq_q[2*PW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.var_ld) begin
      variance <= (msq > sq_new) ? msq - sq_new : '0;
    end
  end

  bbt_sqrt #(.N(PW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.sqrt_start),
    .radicand (variance),
    .done     (sqrt_done),
    .root     (sigma)
  );

  // bands
  assign off   = OW'(band_mult) * OW'(sigma);
  assign upper = UW'(mean) + UW'(off);
  assign lower = (OW'(mean) > off) ? mean - off[PW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (ctl.sum_upd && !full_now) begin
      res_avg   <= '0;
      res_std   <= '0;
      res_upper <= '0;
      res_lower <= '0;
      res_full  <= 1'b0;
    end else if (ctl.band_ld) begin
      res_avg   <= FW'(mean);
      res_std   <= FW'(sigma);
      res_upper <= (upper > UW'(bbt_pkg::FIELD_MAX)) ? bbt_pkg::FIELD_MAX : upper[FW-1:0];
      res_lower <= FW'(lower);
      res_full  <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      m_tdata <= {res_lower, res_upper, res_std, res_avg};
      m_tuser <= res_full;
    end
  end

`include "bollinger_band_tracker_unit_assert.svh"

  `BBT_ASSERT_IMPLY(a_fill_range, clk, rst, 1'b1, fill_count <= FILL_W'(WINDOW))
  `BBT_ASSERT_NEXT(a_one_request, clk, rst, accept, !s_tready)
  `BBT_ASSERT_IMPLY(a_full_flag, clk, rst, m_tvalid && m_tuser, fill_count == FILL_W'(WINDOW))
  `BBT_ASSERT_IMPLY(a_empty_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0)
  `BBT_ASSERT_IMPLY(a_band_order, clk, rst, m_tvalid, (m_tdata[4*FW-1:3*FW] <= m_tdata[FW-1:0]) && (m_tdata[FW-1:0] <= m_tdata[3*FW-1:2*FW]))

endmodule
`default_nettype wire

### sim/bollinger_band_tracker_unit_tb.sv
`timescale 1ns / 1ps

module bollinger_band_tracker_unit_tb;

  localparam int FIELD_W = bbt_pkg::FIELD_W;
  localparam logic [FIELD_W-1:0] FIELD_MAX = bbt_pkg::FIELD_MAX;
  localparam int MULT_W = bbt_pkg::MULT_W;
  localparam logic [MULT_W-1:0] MULT_RESET = bbt_pkg::MULT_RESET;
  localparam int ADDR_W = bbt_pkg::ADDR_W;

  localparam int RING_LEN = 20;
  localparam int HOLD_CYCLES = 1000;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [ADDR_W-1:0] MULT_ADDR = {bbt_pkg::REG_BAND_MULTIPLIER, 2'b00};

  typedef struct packed {
    logic [FIELD_W-1:0] avg;
    logic [FIELD_W-1:0] sigma;
    logic [FIELD_W-1:0] upper;
    logic [FIELD_W-1:0] lower;
    logic               full;
  } band_result_t;

  typedef enum int {PX_ANY, PX_CLUSTER, PX_FLAT, PX_RAILS, PX_LOW, PX_TOP} price_shape_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;                // close_price
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;                     // moving_average, price_sigma, upper, lower
  logic        m_tuser;                     // window_full
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bollinger_band_tracker_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // band model state
  logic [FIELD_W-1:0] price_hist [RING_LEN];
  int                 hist_pos = 0;
  int                 hist_fill = 0;
  logic [63:0]        sum_px = '0;
  logic [63:0]        sum_sq = '0;
  logic [MULT_W-1:0]  band_mult = MULT_RESET;

  band_result_t pending_bands[$];
  int fault_count = 0;
  int burst_left = 0;
  int tx_gap_max = 0;
  int rx_stall_pct = 0;
  int rx_stall_max = 1;
  int rx_run = 0;
  int hold_left = 0;
  logic rx_hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] clip24(input logic [63:0] v);
    return (v > 64'(FIELD_MAX)) ? FIELD_MAX : v[FIELD_W-1:0];
  endfunction

  function automatic band_result_t track_price(input logic [FIELD_W-1:0] price);
    band_result_t r;
    logic [63:0] old_px, px, avg, msq, avg_sq, variance, root, spread, hi, lo;
    px = 64'(price);
    if (hist_fill == RING_LEN) begin
      old_px = 64'(price_hist[hist_pos]);
      sum_px = sum_px - old_px;
      sum_sq = sum_sq - old_px * old_px;
    end
    price_hist[hist_pos] = price;
    sum_px = sum_px + px;
    sum_sq = sum_sq + px * px;
    hist_pos = (hist_pos + 1) % RING_LEN;
    if (hist_fill < RING_LEN) hist_fill++;
    r = '0;
    if (hist_fill < RING_LEN) return r;
    avg = sum_px / RING_LEN;
    msq = sum_sq / RING_LEN;
    avg_sq = avg * avg;
    variance = (msq > avg_sq) ? msq - avg_sq : 64'd0;
    root = floor_root(variance);
    spread = 64'(band_mult) * root;
    hi = avg + spread;
    lo = (avg > spread) ? avg - spread : 64'd0;
    r.avg = clip24(avg);
    r.sigma = clip24(root);
    r.upper = clip24(hi);
    r.lower = clip24(lo);
    r.full = 1'b1;
    return r;
  endfunction

  function automatic void report_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch %s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  // request tracking and result checking
  always @(posedge clk) begin
    band_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) pending_bands.push_back(track_price(s_tdata));
      if (m_tvalid && m_tready) begin
        if (pending_bands.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) $display("unexpected result: %h user %b", m_tdata, m_tuser);
        end else begin
          want = pending_bands.pop_front();
          report_field("moving_average", 32'(want.avg), 32'(m_tdata[23:0]));
          report_field("price_sigma", 32'(want.sigma), 32'(m_tdata[47:24]));
          report_field("upper_band", 32'(want.upper), 32'(m_tdata[71:48]));
          report_field("lower_band", 32'(want.lower), 32'(m_tdata[95:72]));
          report_field("window_full", 32'(want.full), 32'(m_tuser));
        end
      end
    end
  end

  // result acceptor: random stall runs, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_run <= 0;
      hold_left <= 0;
      hold_seen <= rx_hold_toggle;
    end else if (hold_seen != rx_hold_toggle) begin
      hold_seen <= rx_hold_toggle;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (rx_run != 0) begin
      rx_run <= rx_run - 1;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      m_tready <= 1'b0;
      rx_run <= $urandom_range(1, rx_stall_max);
    end else begin
      m_tready <= 1'b1;
      rx_run <= $urandom_range(1, 40);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bollinger_band_tracker_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_price(input logic [FIELD_W-1:0] price);
    int gap;
    if (burst_left == 0) begin
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= price;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_bands.size() != 0);
  endtask

  task automatic check_band_multiplier();
    logic [31:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= MULT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    report_field("band_multiplier readback", 32'(band_mult), 32'(got[MULT_W-1:0]));
  endtask

  task automatic write_band_multiplier(input logic [MULT_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MULT_ADDR;
    pwdata <= {29'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    band_mult = value;
    check_band_multiplier();
  endtask

  function automatic logic [FIELD_W-1:0] pick_price(input price_shape_t shape,
                                                     input logic [FIELD_W-1:0] base,
                                                     input int spread_bits);
    logic [31:0] p;
    case (shape)
      PX_CLUSTER: begin
        p = 32'(base) + $urandom_range(0, (1 << spread_bits));
        if (p > 32'(FIELD_MAX)) p = 32'(FIELD_MAX);
      end
      PX_FLAT:  p = 32'(base);
      PX_RAILS: p = $urandom_range(0, 1) ? 32'(FIELD_MAX) : 32'd0;
      PX_LOW:   p = $urandom_range(0, 255);
      PX_TOP:   p = 32'(FIELD_MAX) - $urandom_range(0, (1 << spread_bits));
      default:  p = $urandom;
    endcase
    return p[FIELD_W-1:0];
  endfunction

  // rails alternate while the window fills: zeros until full, then saturated bands
  task automatic test_window_fill();
    for (int i = 0; i < RING_LEN; i++) send_price((i % 2) ? FIELD_MAX : '0);
    wait_for_results();
  endtask

  // old samples leave the window
  task automatic test_window_slide();
    repeat (4) send_price(FIELD_MAX);
    wait_for_results();
  endtask

  task automatic test_multiplier_extremes();
    write_band_multiplier('0);
    send_price(FIELD_W'($urandom));
    send_price('0);
    wait_for_results();
    write_band_multiplier('1);
    send_price(FIELD_MAX);
    send_price(FIELD_W'($urandom));
    wait_for_results();
  endtask

  task automatic test_random_prices();
    logic [MULT_W-1:0] mult_seq [8] = '{3'd7, 3'd0, 3'd3, 3'd1, 3'd6, 3'd4, 3'd5, 3'd2};
    int gap_seq [8] = '{0, 8, 200, 40, 0, 150, 20, 300};
    int stall_seq [8] = '{0, 30, 50, 10, 0, 70, 40, 20};
    price_shape_t shape;
    logic [FIELD_W-1:0] base;
    int spread_bits, group, sent;
    for (int ph = 0; ph < 8; ph++) begin
      write_band_multiplier(mult_seq[ph]);
      tx_gap_max = gap_seq[ph];
      rx_stall_pct = stall_seq[ph];
      rx_stall_max = (ph % 2) ? 200 : 12;
      sent = 0;
      while (sent < 135) begin
        shape = price_shape_t'($urandom_range(0, 5));
        base = FIELD_W'($urandom);
        spread_bits = $urandom_range(0, 16);
        group = $urandom_range(5, 40);
        repeat (group) send_price(pick_price(shape, base, spread_bits));
        sent += group;
      end
      wait_for_results();
    end
  endtask

  task automatic test_output_backpressure();
    tx_gap_max = 0;
    rx_hold_toggle <= ~rx_hold_toggle;
    repeat (12) send_price(FIELD_W'($urandom));
    wait_for_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    check_band_multiplier();
    test_window_fill();
    test_window_slide();
    test_multiplier_extremes();
    test_random_prices();
    test_output_backpressure();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_bands.size() == 0) begin
      $display("bollinger_band_tracker_unit regression: pass");
    end else begin
      $display("bollinger_band_tracker_unit regression: fail");
    end
    $finish;
  end

endmodule
